// ===== rtl/slstat_pkg.sv =====
// Package for the sensor log statistics core.
// Holds the sizing constants, the set snapshot and result types and the back-end state type.
// Used by every module of the block; depends on nothing.
package slstat_pkg;

  parameter int MAX_READINGS = 65536;

  localparam int CNT_W  = $clog2(MAX_READINGS + 1);
  localparam int TSUM_W = 32 + CNT_W;
  localparam int TEMP_W = 16 + CNT_W;
  localparam int PSUM_W = 32 + CNT_W;

  localparam int DIV_W  = TSUM_W;
  localparam int STEP_W = $clog2(DIV_W + 1);

  localparam int MUL_DIG   = 16;
  localparam int MUL_STEPS = (TSUM_W + MUL_DIG - 1) / MUL_DIG;
  localparam int TPAD_W    = MUL_STEPS * MUL_DIG;
  localparam int PROD_W    = PSUM_W + TPAD_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic signed [15:0] VMIN_RESET = 16'sh7FFF;

  typedef struct packed {
    logic        [TSUM_W-1:0] time_sum;
    logic signed [TEMP_W-1:0] temp_sum;
    logic signed [PSUM_W-1:0] power_sum;
    logic        [14:0]       volt_max;
    logic signed [15:0]       volt_min;
    logic        [CNT_W-1:0]  tally;
    logic                     saturated;
  } snap_t;

  typedef struct packed {
    logic        [31:0] avg_time_ms;
    logic signed [31:0] avg_power_uw;
    logic signed [15:0] avg_temp_centi;
    logic signed [63:0] set_energy;
    logic        [14:0] max_voltage_mv;
    logic signed [15:0] min_voltage_mv;
    logic        [16:0] reading_count;
    logic               count_overflow;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FIN
  } back_state_e;

endpackage

// ===== rtl/sensor_log_statistics_core.sv =====
// Sensor log statistics core: running sums, voltage extremes and per-set averages.
// Readings are taken one per cycle while the queue has room; a set's result is formed
// after its closing item by the bit-serial divider, and the back end takes the next
// snapshot only once the previous result has been loaded into the output register.
// A two-entry snapshot queue lets short sets wait; the input stalls only when it is full.
// Reset clears all sums, the count and the queue, and sets the voltage minimum to 32767.
module sensor_log_statistics_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic        [31:0]  time_ms_i,
  input  logic signed [15:0]  temp_centi_i,
  input  logic signed [15:0]  voltage_mv_i,
  input  logic signed [15:0]  current_ma_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic        [31:0]  avg_time_ms_o,
  output logic signed [31:0]  avg_power_uw_o,
  output logic signed [15:0]  avg_temp_centi_o,
  output logic signed [63:0]  set_energy_o,
  output logic        [14:0]  max_voltage_mv_o,
  output logic signed [15:0]  min_voltage_mv_o,
  output logic        [16:0]  reading_count_o,
  output logic                count_overflow_o
);

  logic                    accept;
  logic                    q_push, q_pop;
  slstat_pkg::snap_t       q_wr_data, q_rd_data;
  slstat_pkg::q_status_t   q_status;
  slstat_pkg::result_t     result;

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  slstat_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .time_ms_i    (time_ms_i),
    .temp_centi_i (temp_centi_i),
    .voltage_mv_i (voltage_mv_i),
    .current_ma_i (current_ma_i),
    .last_i       (last_i),
    .push_o       (q_push),
    .snap_o       (q_wr_data)
  );

  slstat_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (q_wr_data),
    .pop_i     (q_pop),
    .rd_data_o (q_rd_data),
    .status_o  (q_status)
  );

  slstat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .snap_i      (q_rd_data),
    .pop_o       (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign avg_time_ms_o    = result.avg_time_ms;
  assign avg_power_uw_o   = result.avg_power_uw;
  assign avg_temp_centi_o = result.avg_temp_centi;
  assign set_energy_o     = result.set_energy;
  assign max_voltage_mv_o = result.max_voltage_mv;
  assign min_voltage_mv_o = result.min_voltage_mv;
  assign reading_count_o  = result.reading_count;
  assign count_overflow_o = result.count_overflow;

  // The back end never takes a snapshot from an empty queue.
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("snapshot popped from empty queue");

  // The smallest voltage of a set never exceeds its floored largest voltage.
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_voltage_mv_o <= $signed({1'b0, max_voltage_mv_o})))
    else $error("minimum voltage above maximum voltage");

  // An overflowed set reports a full count.
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && count_overflow_o) |->
      (reading_count_o == 17'(slstat_pkg::MAX_READINGS)))
    else $error("count overflow without a full count");

  // A pushed snapshot leaves the queue non-empty in the next cycle.
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> !q_status.empty)
    else $error("queue empty after a push");

endmodule

// ===== rtl/slstat_front.sv =====
// Front end of the sensor log statistics core: accumulates the readings of one set.
// On the closing item it pushes a snapshot of the set into the queue and clears.
// Depends on slstat_pkg.
module slstat_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic        [31:0]  time_ms_i,
  input  logic signed [15:0]  temp_centi_i,
  input  logic signed [15:0]  voltage_mv_i,
  input  logic signed [15:0]  current_ma_i,
  input  logic                last_i,
  output logic                push_o,
  output slstat_pkg::snap_t   snap_o
);

  logic        [slstat_pkg::TSUM_W-1:0] time_sum_q, time_sum_d;
  logic signed [slstat_pkg::TEMP_W-1:0] temp_sum_q, temp_sum_d;
  logic signed [slstat_pkg::PSUM_W-1:0] power_sum_q, power_sum_d;
  logic        [14:0]                   vmax_q, vmax_d;
  logic signed [15:0]                   vmin_q, vmin_d;
  logic        [slstat_pkg::CNT_W-1:0]  tally_q, tally_d;
  logic                                 sat_q, sat_d;
  logic signed [31:0]                   vi_prod;
  logic                                 room;

  assign vi_prod = voltage_mv_i * current_ma_i;
  assign room    = (tally_q != slstat_pkg::CNT_W'(slstat_pkg::MAX_READINGS));

  always_comb begin
    time_sum_d  = time_sum_q;
    temp_sum_d  = temp_sum_q;
    power_sum_d = power_sum_q;
    vmax_d      = vmax_q;
    vmin_d      = vmin_q;
    tally_d     = tally_q;
    sat_d       = sat_q;
    if (room) begin
      time_sum_d  = time_sum_q + slstat_pkg::TSUM_W'(time_ms_i);
      temp_sum_d  = temp_sum_q + slstat_pkg::TEMP_W'(temp_centi_i);
      power_sum_d = power_sum_q + slstat_pkg::PSUM_W'(vi_prod);
      if (voltage_mv_i > $signed({1'b0, vmax_q})) begin
        vmax_d = voltage_mv_i[14:0];
      end
      if (voltage_mv_i < vmin_q) begin
        vmin_d = voltage_mv_i;
      end
      tally_d = tally_q + 1'b1;
    end else begin
      sat_d = 1'b1;
    end
  end

  always_comb begin
    snap_o.time_sum  = time_sum_d;
    snap_o.temp_sum  = temp_sum_d;
    snap_o.power_sum = power_sum_d;
    snap_o.volt_max  = vmax_d;
    snap_o.volt_min  = vmin_d;
    snap_o.tally     = tally_d;
    snap_o.saturated = sat_d;
  end

  assign push_o = accept_i && last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_sum_q  <= '0;
      temp_sum_q  <= '0;
      power_sum_q <= '0;
      vmax_q      <= '0;
      vmin_q      <= slstat_pkg::VMIN_RESET;
      tally_q     <= '0;
      sat_q       <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        time_sum_q  <= '0;
        temp_sum_q  <= '0;
        power_sum_q <= '0;
        vmax_q      <= '0;
        vmin_q      <= slstat_pkg::VMIN_RESET;
        tally_q     <= '0;
        sat_q       <= 1'b0;
      end else begin
        time_sum_q  <= time_sum_d;
        temp_sum_q  <= temp_sum_d;
        power_sum_q <= power_sum_d;
        vmax_q      <= vmax_d;
        vmin_q      <= vmin_d;
        tally_q     <= tally_d;
        sat_q       <= sat_d;
      end
    end
  end

endmodule

// ===== rtl/slstat_queue.sv =====
// Short snapshot queue between the front end and the back end.
// Two register entries with read and write pointers and a fill count.
// Depends on slstat_pkg.
module slstat_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  slstat_pkg::snap_t       wr_data_i,
  input  logic                    pop_i,
  output slstat_pkg::snap_t       rd_data_o,
  output slstat_pkg::q_status_t   status_o
);

  slstat_pkg::snap_t                 entry_q [slstat_pkg::Q_DEPTH];
  logic [slstat_pkg::Q_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [slstat_pkg::Q_CNT_W-1:0]    cnt_q;

  function automatic logic [slstat_pkg::Q_PTR_W-1:0] ptr_next(
    input logic [slstat_pkg::Q_PTR_W-1:0] p
  );
    if (p == slstat_pkg::Q_PTR_W'(slstat_pkg::Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign rd_data_o      = entry_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == slstat_pkg::Q_CNT_W'(slstat_pkg::Q_DEPTH));
  assign status_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/slstat_back.sv =====
// Back end of the sensor log statistics core: divides the three sums by the count
// one quotient bit per cycle and forms the energy product one 16-bit digit per cycle.
// Holds the result in an output register. Depends on slstat_pkg.
module slstat_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  slstat_pkg::q_status_t   q_status_i,
  input  slstat_pkg::snap_t       snap_i,
  output logic                    pop_o,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output slstat_pkg::result_t     result_o
);

  slstat_pkg::back_state_e state_q, state_d;

  logic [slstat_pkg::STEP_W-1:0]  step_q;
  logic [slstat_pkg::CNT_W-1:0]   div_q;
  logic [14:0]                    vmax_q;
  logic signed [15:0]             vmin_q;
  logic                           sat_q;
  logic                           pneg_q, tneg_q;

  logic [slstat_pkg::DIV_W-1:0]   dt_q, dp_q, dm_q;
  logic [slstat_pkg::CNT_W-1:0]   rt_q, rp_q, rm_q;
  logic [slstat_pkg::DIV_W-1:0]   dt_d, dp_d, dm_d;
  logic [slstat_pkg::CNT_W-1:0]   rt_d, rp_d, rm_d;

  logic [slstat_pkg::PSUM_W-1:0]  mag_q;
  logic [slstat_pkg::TPAD_W-1:0]  tmul_q;
  logic [slstat_pkg::PROD_W-1:0]  acc_q;
  logic [slstat_pkg::PSUM_W+slstat_pkg::MUL_DIG-1:0] part;

  logic [slstat_pkg::PSUM_W-1:0]  pmag;
  logic [slstat_pkg::TEMP_W-1:0]  tmag;

  logic                           out_valid_q;
  slstat_pkg::result_t            result_q, result_d;

  logic                           out_free;
  logic                           start, running, load_out, last_step;

  logic [slstat_pkg::DIV_W-1:0]   qp_s, qm_s;
  logic [63:0]                    prod_neg;
  logic                           sat_neg, sat_pos;

  function automatic logic [slstat_pkg::DIV_W+slstat_pkg::CNT_W-1:0] div_step(
    input logic [slstat_pkg::CNT_W-1:0] rem,
    input logic [slstat_pkg::DIV_W-1:0] dvd,
    input logic [slstat_pkg::CNT_W-1:0] dsr
  );
    logic [slstat_pkg::CNT_W:0] sh;
    logic                       ge;
    logic [slstat_pkg::CNT_W:0] diff;
    sh   = {rem, dvd[slstat_pkg::DIV_W-1]};
    ge   = (sh >= {1'b0, dsr});
    diff = sh - {1'b0, dsr};
    return {(ge ? diff[slstat_pkg::CNT_W-1:0] : sh[slstat_pkg::CNT_W-1:0]),
            dvd[slstat_pkg::DIV_W-2:0], ge};
  endfunction

  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_step = (step_q == slstat_pkg::STEP_W'(slstat_pkg::DIV_W - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      slstat_pkg::BK_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = slstat_pkg::BK_RUN;
        end
      end
      slstat_pkg::BK_RUN: begin
        if (last_step) begin
          state_d = slstat_pkg::BK_FIN;
        end
      end
      slstat_pkg::BK_FIN: begin
        if (out_free) begin
          state_d = slstat_pkg::BK_IDLE;
        end
      end
      default: state_d = slstat_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    start    = 1'b0;
    running  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      slstat_pkg::BK_IDLE: start    = !q_status_i.empty;
      slstat_pkg::BK_RUN:  running  = 1'b1;
      slstat_pkg::BK_FIN:  load_out = out_free;
      default: begin
        start    = 1'b0;
        running  = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign pop_o = start;

  assign pmag = snap_i.power_sum[slstat_pkg::PSUM_W-1] ? -snap_i.power_sum
                                                        : snap_i.power_sum;
  assign tmag = snap_i.temp_sum[slstat_pkg::TEMP_W-1] ? -snap_i.temp_sum
                                                      : snap_i.temp_sum;

  assign {rt_d, dt_d} = div_step(rt_q, dt_q, div_q);
  assign {rp_d, dp_d} = div_step(rp_q, dp_q, div_q);
  assign {rm_d, dm_d} = div_step(rm_q, dm_q, div_q);

  assign part = mag_q * tmul_q[slstat_pkg::TPAD_W-1 -: slstat_pkg::MUL_DIG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slstat_pkg::BK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (start) begin
        step_q <= '0;
      end else if (running) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      div_q  <= snap_i.tally;
      vmax_q <= snap_i.volt_max;
      vmin_q <= snap_i.volt_min;
      sat_q  <= snap_i.saturated;
      pneg_q <= snap_i.power_sum[slstat_pkg::PSUM_W-1];
      tneg_q <= snap_i.temp_sum[slstat_pkg::TEMP_W-1];
      dt_q   <= slstat_pkg::DIV_W'(snap_i.time_sum);
      dp_q   <= slstat_pkg::DIV_W'(pmag);
      dm_q   <= slstat_pkg::DIV_W'(tmag);
      rt_q   <= '0;
      rp_q   <= '0;
      rm_q   <= '0;
      mag_q  <= pmag;
      tmul_q <= slstat_pkg::TPAD_W'(snap_i.time_sum);
      acc_q  <= '0;
    end else if (running) begin
      dt_q <= dt_d;
      dp_q <= dp_d;
      dm_q <= dm_d;
      rt_q <= rt_d;
      rp_q <= rp_d;
      rm_q <= rm_d;
      if (step_q < slstat_pkg::STEP_W'(slstat_pkg::MUL_STEPS)) begin
        acc_q  <= (acc_q << slstat_pkg::MUL_DIG) + slstat_pkg::PROD_W'(part);
        tmul_q <= tmul_q << slstat_pkg::MUL_DIG;
      end
    end
  end

  assign qp_s     = pneg_q ? -dp_q : dp_q;
  assign qm_s     = tneg_q ? -dm_q : dm_q;
  assign prod_neg = -acc_q[63:0];
  assign sat_neg  = (|acc_q[slstat_pkg::PROD_W-1:64]) || (acc_q[63] && (|acc_q[62:0]));
  assign sat_pos  = |acc_q[slstat_pkg::PROD_W-1:63];

  always_comb begin
    result_d.avg_time_ms    = dt_q[31:0];
    result_d.avg_power_uw   = qp_s[31:0];
    result_d.avg_temp_centi = qm_s[15:0];
    if (pneg_q) begin
      result_d.set_energy = sat_neg ? 64'sh8000_0000_0000_0000 : prod_neg;
    end else begin
      result_d.set_energy = sat_pos ? 64'sh7FFF_FFFF_FFFF_FFFF : acc_q[63:0];
    end
    result_d.max_voltage_mv = vmax_q;
    result_d.min_voltage_mv = vmin_q;
    result_d.reading_count  = 17'(div_q);
    result_d.count_overflow = sat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// ===== tb/sensor_log_statistics_core_test.sv =====
// Self-checking testbench for sensor_log_statistics_core: a scoreboard class predicts each
// set's averages, energy, voltage extremes and count from the accepted readings.
// Depends on slstat_pkg and the core only; random stimulus comes from $urandom.
module sensor_log_statistics_core_test;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 120;
  localparam int RANDOM_READINGS = 1650;
  localparam int LONG_HOLD       = 600;

  localparam logic signed [15:0]  S16_MIN    = 16'sh8000;
  localparam logic signed [15:0]  S16_MAX    = 16'sh7FFF;
  localparam logic signed [127:0] ENERGY_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] ENERGY_MIN = -128'sh8000_0000_0000_0000;

  class set_statistics_board;
    longint unsigned     time_total;
    longint              temp_total;
    longint              power_total;
    int                  volt_high;
    int                  volt_low;
    int unsigned         tally;
    bit                  saturated;
    slstat_pkg::result_t pending_summaries[$];
    int                  mismatch_count;

    function new();
      mismatch_count = 0;
      clear();
    endfunction

    function void clear();
      time_total  = 0;
      temp_total  = 0;
      power_total = 0;
      volt_high   = 0;
      volt_low    = slstat_pkg::VMIN_RESET;
      tally       = 0;
      saturated   = 1'b0;
    endfunction

    function int outstanding();
      return pending_summaries.size();
    endfunction

    function void take_reading(logic [31:0] t, logic signed [15:0] temp,
                               logic signed [15:0] volt, logic signed [15:0] amps,
                               logic closes);
      slstat_pkg::result_t s;
      logic signed [127:0] prod;
      logic signed [127:0] time_wide;
      longint              n;
      // A reading that arrives with the count full only marks the overflow.
      if (tally < slstat_pkg::MAX_READINGS) begin
        time_total  += t;
        temp_total  += temp;
        power_total += longint'(volt) * longint'(amps);
        if (volt > volt_high) volt_high = volt;
        if (volt < volt_low) volt_low = volt;
        tally++;
      end else begin
        saturated = 1'b1;
      end
      if (!closes) return;
      n = longint'(tally);
      s.avg_time_ms    = 32'(time_total / 64'(tally));
      s.avg_power_uw   = 32'(power_total / n);
      s.avg_temp_centi = 16'(temp_total / n);
      time_wide = {64'd0, time_total};
      prod = power_total;
      prod = prod * time_wide;
      if (prod > ENERGY_MAX) begin
        s.set_energy = ENERGY_MAX[63:0];
      end else if (prod < ENERGY_MIN) begin
        s.set_energy = ENERGY_MIN[63:0];
      end else begin
        s.set_energy = prod[63:0];
      end
      s.max_voltage_mv = volt_high[14:0];
      s.min_voltage_mv = volt_low[15:0];
      s.reading_count  = tally[16:0];
      s.count_overflow = saturated;
      pending_summaries.push_back(s);
      clear();
    endfunction

    task report(string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task field_check(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen)
        report($sformatf("%s expected %0h, got %0h", name, want, seen));
    endtask

    task check_summary(slstat_pkg::result_t got);
      slstat_pkg::result_t want;
      if (pending_summaries.size() == 0) begin
        report("result arrived with no set pending");
        return;
      end
      want = pending_summaries.pop_front();
      field_check("avg_time_ms", want.avg_time_ms, got.avg_time_ms);
      field_check("avg_power_uw", want.avg_power_uw, got.avg_power_uw);
      field_check("avg_temp_centi", want.avg_temp_centi, got.avg_temp_centi);
      field_check("set_energy", want.set_energy, got.set_energy);
      field_check("max_voltage_mv", want.max_voltage_mv, got.max_voltage_mv);
      field_check("min_voltage_mv", want.min_voltage_mv, got.min_voltage_mv);
      field_check("reading_count", want.reading_count, got.reading_count);
      field_check("count_overflow", want.count_overflow, got.count_overflow);
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic        [31:0] time_ms_i;
  logic signed [15:0] temp_centi_i;
  logic signed [15:0] voltage_mv_i;
  logic signed [15:0] current_ma_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic        [31:0] avg_time_ms_o;
  logic signed [31:0] avg_power_uw_o;
  logic signed [15:0] avg_temp_centi_o;
  logic signed [63:0] set_energy_o;
  logic        [14:0] max_voltage_mv_o;
  logic signed [15:0] min_voltage_mv_o;
  logic        [16:0] reading_count_o;
  logic               count_overflow_o;

  set_statistics_board board;
  bit                  tx_idle;
  bit                  rx_idle;
  int                  hold_requests;
  int                  readings_sent;

  sensor_log_statistics_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .time_ms_i        (time_ms_i),
    .temp_centi_i     (temp_centi_i),
    .voltage_mv_i     (voltage_mv_i),
    .current_ma_i     (current_ma_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .avg_time_ms_o    (avg_time_ms_o),
    .avg_power_uw_o   (avg_power_uw_o),
    .avg_temp_centi_o (avg_temp_centi_o),
    .set_energy_o     (set_energy_o),
    .max_voltage_mv_o (max_voltage_mv_o),
    .min_voltage_mv_o (min_voltage_mv_o),
    .reading_count_o  (reading_count_o),
    .count_overflow_o (count_overflow_o)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [15:0] pick_s16();
    case ($urandom_range(0, 11))
      0: return S16_MIN;
      1: return S16_MAX;
      2: return 16'sd0;
      3: return -16'sd1;
      4, 5: return 16'($urandom_range(0, 200)) - 16'sd100;
      default: return 16'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_reading(logic [31:0] t, logic signed [15:0] temp,
                              logic signed [15:0] volt, logic signed [15:0] amps,
                              logic closes);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    time_ms_i    = t;
    temp_centi_i = temp;
    voltage_mv_i = volt;
    current_ma_i = amps;
    last_i       = closes;
    do @(posedge clk_i); while (in_stall_o);
    board.take_reading(t, temp, volt, amps, closes);
    readings_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random_set(int len);
    logic [31:0] stamp;
    logic [31:0] step;
    bit          wide_time;
    wide_time = $urandom_range(0, 3) == 0;
    stamp     = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
    step      = $urandom_range(1, 1000);
    for (int k = 0; k < len; k++) begin
      send_reading(wide_time ? 32'($urandom) : stamp, pick_s16(), pick_s16(), pick_s16(),
                   k == len - 1);
      stamp += step;
    end
  endtask

  task automatic wait_results_drained();
    in_valid_i = 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : result_sink
    int                  wait_cycles;
    int                  holds_served;
    slstat_pkg::result_t got;
    holds_served = 0;
    out_stall_i  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        out_stall_i  = 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      wait_cycles = rx_idle ? $urandom_range(0, 9) : 0;
      if (wait_cycles > 0) begin
        out_stall_i = 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.avg_time_ms    = avg_time_ms_o;
      got.avg_power_uw   = avg_power_uw_o;
      got.avg_temp_centi = avg_temp_centi_o;
      got.set_energy     = set_energy_o;
      got.max_voltage_mv = max_voltage_mv_o;
      got.min_voltage_mv = min_voltage_mv_o;
      got.reading_count  = reading_count_o;
      got.count_overflow = count_overflow_o;
      board.check_summary(got);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("sensor_log_statistics_core verification failed");
    $finish;
  end

  initial begin : stimulus
    int set_len;
    int chunk;
    int random_goal;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    time_ms_i      = '0;
    temp_centi_i   = '0;
    voltage_mv_i   = '0;
    current_ma_i   = '0;
    last_i         = 1'b0;
    tx_idle        = 1'b0;
    rx_idle        = 1'b0;
    hold_requests  = 0;
    readings_sent  = 0;
    board = new();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed sets: field extremes, no positive voltage, energy clamped both ways,
    // truncation toward zero, and a minimum that never leaves its reset value.
    send_reading(32'd0, S16_MIN, S16_MIN, S16_MIN, 1'b1);
    send_reading(32'hFFFF_FFFF, S16_MAX, S16_MAX, S16_MAX, 1'b1);
    send_reading(32'hFFFF_FFFF, S16_MAX, S16_MIN, S16_MIN, 1'b0);
    send_reading(32'hFFFF_FFFF, S16_MAX, S16_MIN, S16_MIN, 1'b1);
    send_reading(32'hFFFF_FFFF, S16_MIN, S16_MAX, S16_MIN, 1'b0);
    send_reading(32'hFFFF_FFFF, S16_MIN, S16_MAX, S16_MIN, 1'b1);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_reading(32'd1000, -16'sd1, -16'sd5, 16'sd3, 1'b0);
    send_reading(32'd1001, -16'sd1, -16'sd7, 16'sd1, 1'b0);
    send_reading(32'd1003, 16'sd0, -16'sd2, -16'sd1, 1'b1);
    send_reading(32'd7, 16'sd0, S16_MAX, 16'sd0, 1'b0);
    send_reading(32'd8, 16'sd0, S16_MAX, 16'sd0, 1'b1);
    wait_results_drained();

    chunk = 0;
    random_goal = readings_sent + RANDOM_READINGS;
    while (readings_sent < random_goal) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if (chunk == 2 || chunk == 12) begin
        tx_idle = 1'b0;
        hold_requests++;
        repeat (40) send_random_set($urandom_range(1, 3));
        wait_results_drained();
      end
      repeat (8) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: set_len = $urandom_range(1, 4);
          6, 7, 8: set_len = $urandom_range(5, 20);
          default: set_len = $urandom_range(21, 60);
        endcase
        send_random_set(set_len);
      end
      if (chunk % 4 == 1) wait_results_drained();
      chunk++;
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.outstanding() != 0)
      board.report($sformatf("%0d expected results never arrived", board.outstanding()));
    if (board.mismatch_count == 0) begin
      $display("sensor_log_statistics_core verification clean");
    end else begin
      $display("sensor_log_statistics_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/slstat_pkg.sv
rtl/slstat_front.sv
rtl/slstat_queue.sv
rtl/slstat_back.sv
rtl/sensor_log_statistics_core.sv
tb/sensor_log_statistics_core_test.sv
